/* hdl/sample_histogram_statistics_defines.svh */
// ----------------------------------------------------------------------------
// Sample histogram statistics assertion macros
// Shared concurrent assertion forms used by the statistics block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_STATISTICS_DEFINES_SVH
`define SAMPLE_HISTOGRAM_STATISTICS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sample_histogram_statistics: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define SHS_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sample_histogram_statistics: next-cycle property failed");

`endif

/* hdl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// Sample histogram statistics package
// Constants, opcodes and transaction types shared by the statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

	localparam int NumBins  = 64;
	localparam int BinIdxW  = $clog2(NumBins);
	localparam int DivStepW = 5;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} shs_op_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] sample_value;
		logic [5:0]         bin_select;
	} shs_cmd_t;

	typedef struct packed {
		logic [31:0]        sample_count;
		logic signed [63:0] sample_total;
		logic signed [31:0] smallest;
		logic signed [31:0] largest;
		logic signed [31:0] mean_value;
		logic [31:0]        bin_value;
		logic               is_empty;
	} shs_result_t;

	typedef struct packed {
		logic                go;
		logic [31:0]         rem_init;
		logic [30:0]         low_bits;
		logic [DivStepW-1:0] steps;
		logic [31:0]         divisor;
	} shs_div_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [30:0] quot;
	} shs_div_rsp_t;

endpackage

`default_nettype wire

/* hdl/shs_div.sv */
// ----------------------------------------------------------------------------
// Shared bit-serial divider
// Restoring divider that develops one quotient bit per cycle and flags a
// quotient that would not fit in the requested number of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shs_pkg::shs_div_req_t req,
	output shs_pkg::shs_div_rsp_t rsp
);
	import shs_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_CHECK,
		D_RUN
	} div_state_t;

	div_state_t          state_q;
	logic [DivStepW-1:0] cnt_q;
	logic                done_q;
	logic                ovf_q;
	logic [31:0]         rem_q;
	logic [31:0]         div_q;
	logic [30:0]         low_q;
	logic [30:0]         quot_q;
	logic [32:0]         trial;
	logic [32:0]         diff;
	logic                ge;

	always_comb begin
		trial = (state_q == D_CHECK) ? {1'b0, rem_q} : {rem_q, low_q[30]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.go) begin
						rem_q   <= req.rem_init;
						low_q   <= req.low_bits;
						div_q   <= req.divisor;
						cnt_q   <= req.steps;
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					ovf_q  <= ge;
					quot_q <= '0;
					if (ge) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q  <= ge ? diff[31:0] : trial[31:0];
					quot_q <= {quot_q[29:0], ge};
					low_q  <= {low_q[29:0], 1'b0};
					cnt_q  <= cnt_q - DivStepW'(1);
					if (cnt_q == DivStepW'(1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

/* hdl/sample_histogram_statistics.sv */
// ----------------------------------------------------------------------------
// Sample histogram statistics
// Running count, saturating sum, minimum, maximum, mean and a binned
// histogram over signed 32-bit samples.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and its single
// result appears for exactly one cycle with done high; the receiver cannot
// stall it. Clear and unknown opcodes go straight to the report state and a
// bin read passes through a read state first. An add waits on one shared
// bit-serial divider, which first finds the bin of a non-negative sample
// in log2(bins) steps and then the mean in 31 steps, each after a check
// state; a division whose quotient cannot fit ends at that check, which
// shortens the add.
// bin_width may be written only while busy is low and no result is pending.
`default_nettype none

`include "sample_histogram_statistics_defines.svh"

module sample_histogram_statistics (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  shs_pkg::shs_cmd_t    cmd,
	output logic                 done,
	output shs_pkg::shs_result_t result,
	input  logic                 cfg_write,
	input  logic [15:0]          cfg_data
);
	import shs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BIN_GO,
		S_BIN_WAIT,
		S_RD,
		S_WR,
		S_MEAN_MAG,
		S_MEAN_GO,
		S_MEAN_WAIT,
		S_READ,
		S_REPORT
	} state_t;

	state_t              state_q;
	logic [15:0]         bin_width_q;
	logic [31:0]         count_q;
	logic signed [63:0]  total_q;
	logic signed [31:0]  min_q;
	logic signed [31:0]  max_q;
	logic signed [31:0]  mean_q;
	logic                empty_q;
	logic [NumBins-1:0]  valid_q;
	logic signed [31:0]  sample_q;
	logic [BinIdxW-1:0]  bin_idx_q;
	logic                sel_ok_q;
	logic [31:0]         binv_q;
	logic [63:0]         mag_q;
	logic                neg_q;
	logic                done_q;
	shs_result_t         result_q;
	logic [31:0]         bin_mem_q [NumBins];
	logic [31:0]         rd_data_q;

	logic [15:0]         width_eff;
	logic [63:0]         sample_ext;
	logic [63:0]         sum_raw;
	logic                sum_ovf;
	logic [BinIdxW-1:0]  rd_addr;
	logic                mem_we;
	logic [31:0]         bin_old;
	logic [31:0]         mem_wdata;
	logic [31:0]         mean_pos;
	shs_div_req_t        div_req;
	shs_div_rsp_t        div_rsp;

	shs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		width_eff  = (bin_width_q == '0) ? 16'd1 : bin_width_q;
		sample_ext = {{32{cmd.sample_value[31]}}, cmd.sample_value};
		sum_raw    = total_q + sample_ext;
		sum_ovf    = (total_q[63] == cmd.sample_value[31]) &&
			(sum_raw[63] != cmd.sample_value[31]);
		rd_addr    = (state_q == S_IDLE) ? BinIdxW'(cmd.bin_select) : bin_idx_q;
		mem_we     = (state_q == S_WR);
		bin_old    = valid_q[bin_idx_q] ? rd_data_q : 32'd0;
		mem_wdata  = (bin_old == 32'hFFFF_FFFF) ? bin_old : bin_old + 32'd1;
		mean_pos   = {1'b0, div_rsp.quot};

		if (state_q == S_MEAN_GO) begin
			div_req.go       = 1'b1;
			div_req.rem_init = mag_q[62:31];
			div_req.low_bits = mag_q[30:0];
			div_req.steps    = DivStepW'(31);
			div_req.divisor  = count_q;
		end else begin
			div_req.go       = (state_q == S_BIN_GO) && !sample_q[31];
			div_req.rem_init = 32'(sample_q[30:0] >> BinIdxW);
			div_req.low_bits = 31'(sample_q[30:0] << (31 - BinIdxW));
			div_req.steps    = DivStepW'(BinIdxW);
			div_req.divisor  = {16'd0, width_eff};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem_q[bin_idx_q] <= mem_wdata;
		end
		rd_data_q <= bin_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bin_width_q <= 16'd1;
			count_q     <= '0;
			total_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			mean_q      <= '0;
			empty_q     <= 1'b1;
			valid_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				bin_width_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						binv_q    <= '0;
						bin_idx_q <= BinIdxW'(cmd.bin_select);
						sel_ok_q  <= 32'(cmd.bin_select) < 32'(NumBins);
						unique case (cmd.opcode)
							OP_ADD: begin
								sample_q <= cmd.sample_value;
								if (count_q != 32'hFFFF_FFFF) begin
									count_q <= count_q + 32'd1;
								end
								if (sum_ovf) begin
									total_q <= cmd.sample_value[31] ?
										64'sh8000_0000_0000_0000 :
										64'sh7FFF_FFFF_FFFF_FFFF;
								end else begin
									total_q <= sum_raw;
								end
								if (empty_q) begin
									min_q <= cmd.sample_value;
									max_q <= cmd.sample_value;
								end else begin
									if (cmd.sample_value < min_q) begin
										min_q <= cmd.sample_value;
									end
									if (cmd.sample_value > max_q) begin
										max_q <= cmd.sample_value;
									end
								end
								empty_q <= 1'b0;
								state_q <= S_BIN_GO;
							end
							OP_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
								min_q   <= '0;
								max_q   <= '0;
								mean_q  <= '0;
								empty_q <= 1'b1;
								valid_q <= '0;
								state_q <= S_REPORT;
							end
							OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_REPORT;
							end
						endcase
					end
				end
				S_BIN_GO: begin
					if (sample_q[31]) begin
						bin_idx_q <= '0;
						state_q   <= S_RD;
					end else begin
						state_q <= S_BIN_WAIT;
					end
				end
				S_BIN_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.ovf || (div_rsp.quot >= 31'(NumBins))) begin
							bin_idx_q <= BinIdxW'(NumBins - 1);
						end else begin
							bin_idx_q <= div_rsp.quot[BinIdxW-1:0];
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					valid_q[bin_idx_q] <= 1'b1;
					state_q            <= S_MEAN_MAG;
				end
				S_MEAN_MAG: begin
					neg_q <= total_q[63];
					mag_q <= total_q[63] ? (64'd0 - total_q) : total_q;
					if (empty_q || (count_q == '0)) begin
						mean_q  <= '0;
						state_q <= S_REPORT;
					end else begin
						state_q <= S_MEAN_GO;
					end
				end
				S_MEAN_GO: begin
					state_q <= S_MEAN_WAIT;
				end
				S_MEAN_WAIT: begin
					if (div_rsp.done) begin
						if (mag_q[63] || div_rsp.ovf) begin
							mean_q <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
						end else begin
							mean_q <= neg_q ? (32'd0 - mean_pos) : mean_pos;
						end
						state_q <= S_REPORT;
					end
				end
				S_READ: begin
					binv_q  <= (sel_ok_q && valid_q[bin_idx_q]) ? rd_data_q : 32'd0;
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					result_q.sample_count <= count_q;
					result_q.sample_total <= total_q;
					result_q.smallest     <= empty_q ? 32'sd0 : min_q;
					result_q.largest      <= empty_q ? 32'sd0 : max_q;
					result_q.mean_value   <= mean_q;
					result_q.bin_value    <= binv_q;
					result_q.is_empty     <= empty_q;
					done_q                <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`SHS_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)
	`SHS_ASSERT_NXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy)
	`SHS_ASSERT_IMP(a_empty_count, clk, arst_n, done,
		result.is_empty == (result.sample_count == 32'd0))
	`SHS_ASSERT_IMP(a_empty_zero_stats, clk, arst_n, done && result.is_empty,
		(result.smallest == 32'sd0) && (result.largest == 32'sd0) &&
		(result.mean_value == 32'sd0) && (result.sample_total == 64'sd0))

endmodule

`default_nettype wire

/* sim/sample_histogram_statistics_tb.sv */
// ----------------------------------------------------------------------------
// Sample histogram statistics testbench
// Sends add, clear, read and unknown transactions to the statistics block
// under several bin widths and sender idle patterns. A behavioral predictor
// tracks count, sum, min, max, mean and the bins, and every result is
// compared field by field with the expected one, in order.
// ----------------------------------------------------------------------------
module sample_histogram_statistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import shs_pkg::*;

	localparam logic [1:0]          OpUnknown = 2'd3;
	localparam longint              SumMax    = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint              SumMin    = -SumMax - 1;
	localparam logic signed [31:0]  SampleMax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]  SampleMin = 32'sh8000_0000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	shs_cmd_t    cmd;
	logic        done;
	shs_result_t result;
	logic        cfg_write;
	logic [15:0] cfg_data;

	sample_histogram_statistics dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block's state.
	logic [15:0]        shadow_width;
	logic [31:0]        shadow_count;
	longint             shadow_total;
	logic signed [31:0] shadow_min;
	logic signed [31:0] shadow_max;
	logic               shadow_empty;
	logic [31:0]        shadow_bins [NumBins];

	shs_result_t pending_stats[$];
	shs_result_t oldest_stats;

	int idle_pct;
	int failures;
	int n_checked;
	int n_adds;
	int n_clears;
	int n_reads;
	int n_unknown;

	function automatic void clear_shadow();
		shadow_count = '0;
		shadow_total = 0;
		shadow_min   = '0;
		shadow_max   = '0;
		shadow_empty = 1'b1;
		for (int i = 0; i < NumBins; i++) shadow_bins[i] = '0;
	endfunction

	function automatic logic signed [31:0] running_mean();
		logic [63:0] mag;
		logic [63:0] quo;
		logic        neg;
		if (shadow_empty || shadow_count == 0) return '0;
		neg = shadow_total < 0;
		mag = neg ? 64'(-(shadow_total + 1)) + 64'd1 : 64'(shadow_total);
		quo = mag / {32'd0, shadow_count};
		if (neg) begin
			if (quo >= 64'h8000_0000) return SampleMin;
			return 32'(32'd0 - quo[31:0]);
		end
		if (quo > 64'h7FFF_FFFF) return SampleMax;
		return quo[31:0];
	endfunction

	function automatic void accumulate_sample(logic signed [31:0] v);
		longint      v64;
		logic [31:0] w;
		logic [31:0] quo;
		int          b;
		v64 = longint'(v);
		w = (shadow_width == 0) ? 32'd1 : {16'd0, shadow_width};
		if (shadow_count != 32'hFFFF_FFFF) shadow_count++;
		if (v64 > 0 && shadow_total > SumMax - v64) shadow_total = SumMax;
		else if (v64 < 0 && shadow_total < SumMin - v64) shadow_total = SumMin;
		else shadow_total = shadow_total + v64;
		if (shadow_empty) begin
			shadow_empty = 1'b0;
			shadow_min = v;
			shadow_max = v;
		end else begin
			if (v > shadow_max) shadow_max = v;
			if (v < shadow_min) shadow_min = v;
		end
		if (v < 0) begin
			b = 0;
		end else begin
			quo = 32'(v) / w;
			b = (quo >= NumBins) ? NumBins - 1 : int'(quo);
		end
		if (shadow_bins[b] != 32'hFFFF_FFFF) shadow_bins[b]++;
	endfunction

	function automatic void predict_statistics(shs_cmd_t c);
		shs_result_t r;
		logic [31:0] bin_read;
		bin_read = '0;
		case (c.opcode)
			OP_ADD: begin
				accumulate_sample(c.sample_value);
				n_adds++;
			end
			OP_CLEAR: begin
				clear_shadow();
				n_clears++;
			end
			OP_READ: begin
				if (int'(c.bin_select) < NumBins) bin_read = shadow_bins[c.bin_select];
				n_reads++;
			end
			default: n_unknown++;
		endcase
		r.sample_count = shadow_count;
		r.sample_total = shadow_total;
		r.smallest     = shadow_empty ? '0 : shadow_min;
		r.largest      = shadow_empty ? '0 : shadow_max;
		r.mean_value   = running_mean();
		r.bin_value    = bin_read;
		r.is_empty     = shadow_empty;
		pending_stats.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_stats.size() == 0) begin
				$error("result with no transaction outstanding");
				failures++;
			end else begin
				oldest_stats = pending_stats.pop_front();
				check_field("sample_count", oldest_stats.sample_count, result.sample_count);
				check_field("sample_total", $signed(oldest_stats.sample_total),
					$signed(result.sample_total));
				check_field("smallest", $signed(oldest_stats.smallest), $signed(result.smallest));
				check_field("largest", $signed(oldest_stats.largest), $signed(result.largest));
				check_field("mean_value", $signed(oldest_stats.mean_value),
					$signed(result.mean_value));
				check_field("bin_value", oldest_stats.bin_value, result.bin_value);
				check_field("is_empty", oldest_stats.is_empty, result.is_empty);
				n_checked++;
			end
		end
	end

	// Start stays high between back-to-back transactions; it drops only for a gap or in wait_idle.
	task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] val,
			input logic [5:0] sel);
		shs_cmd_t c;
		int       gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.opcode       = op;
		c.sample_value = val;
		c.bin_select   = sel;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		predict_statistics(c);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_bin_width(input logic [15:0] w);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data  <= w;
		@(posedge clk);
		cfg_write <= 1'b0;
		shadow_width = w;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_sample();
		logic [31:0] w;
		logic [31:0] k;
		w = (shadow_width == 0) ? 32'd1 : {16'd0, shadow_width};
		k = $urandom_range(0, 64);
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? SampleMax : SampleMin;
			1:       return -$signed({1'b0, 31'($urandom)}) - 1;
			7:       return $urandom;
			8:       return k * w - $urandom_range(1);
			9:       return $signed(32'($urandom_range(200))) - 100;
			default: return $urandom_range(0, w * 66);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_cmd(OP_READ, 0, 0);
		send_cmd(OpUnknown, 0, 6'd63);
	endtask

	task automatic test_extreme_samples();
		send_cmd(OP_ADD, 0, 0);
		send_cmd(OP_ADD, -1, 0);
		send_cmd(OP_ADD, SampleMax, 0);
		send_cmd(OP_ADD, SampleMin, 0);
		send_cmd(OP_ADD, 63, 0);
		send_cmd(OP_ADD, 62, 0);
		send_cmd(OP_READ, 0, 0);
		send_cmd(OP_READ, 0, 6'd62);
		send_cmd(OP_READ, 0, 6'd63);
		send_cmd(OP_READ, 0, 6'd1);
		send_cmd(OpUnknown, 32'sh5A5A_A5A5, 6'd63);
	endtask

	task automatic test_clear();
		send_cmd(OP_CLEAR, 32'sh1234_5678, 6'd17);
		send_cmd(OP_READ, 0, 6'd63);
		send_cmd(OP_ADD, -5, 0);
		send_cmd(OP_ADD, -2, 0);
	endtask

	task automatic test_zero_width();
		write_bin_width(16'd0);
		send_cmd(OP_ADD, 5, 0);
		send_cmd(OP_READ, 0, 6'd5);
	endtask

	task automatic test_wide_bins();
		write_bin_width(16'hFFFF);
		send_cmd(OP_ADD, 65534, 0);
		send_cmd(OP_ADD, 65535, 0);
		send_cmd(OP_READ, 0, 6'd1);
		send_cmd(OP_ADD, SampleMax, 0);
		send_cmd(OP_READ, 0, 6'd63);
		send_cmd(OP_CLEAR, 0, 0);
	endtask

	task automatic test_random_traffic(input int pct, input logic [15:0] w0,
			input logic [15:0] w1);
		logic [15:0] widths [4];
		int          sel;
		idle_pct = 0;
		widths[0] = w0;
		widths[1] = w1;
		widths[2] = 16'($urandom_range(2, 300));
		widths[3] = 16'($urandom_range(2, 65535));
		foreach (widths[i]) begin
			write_bin_width(widths[i]);
			idle_pct = pct;
			repeat (131) begin
				sel = $urandom_range(99);
				if (sel < 55) send_cmd(OP_ADD, pick_sample(), 6'($urandom));
				else if (sel < 85) send_cmd(OP_READ, $urandom, 6'($urandom));
				else if (sel < 92) send_cmd(OP_CLEAR, $urandom, 6'($urandom));
				else send_cmd(OpUnknown, $urandom, 6'($urandom));
			end
			idle_pct = 0;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_write = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		failures  = 0;
		n_checked = 0;
		n_adds    = 0;
		n_clears  = 0;
		n_reads   = 0;
		n_unknown = 0;
		shadow_width = 16'd1;
		clear_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extreme_samples();
		test_clear();
		test_zero_width();
		test_wide_bins();
		test_random_traffic(8, 16'd1, 16'd3);
		test_random_traffic(88, 16'd0, 16'hFFFF);
		test_random_traffic(0, 16'd100, 16'd50000);

		wait_idle();
		repeat (60) @(posedge clk);
		$display("Checked %0d results: %0d adds, %0d clears, %0d bin reads, %0d unknown opcodes.",
			n_checked, n_adds, n_clears, n_reads, n_unknown);
		$display("Bin widths 0, 1, 65535 and random values were used under three idle patterns.");
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$error("timeout with %0d transactions outstanding", pending_stats.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/shs_pkg.sv
hdl/shs_div.sv
hdl/sample_histogram_statistics.sv
sim/sample_histogram_statistics_tb.sv
